/* rtl/slfd_pkg.sv */
// Shared types and constants for the sync/length frame deframer.
// Used by slfd_parser and sync_length_frame_deframer_core; no dependencies.
package slfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FLEN_W   = 13;
  localparam int unsigned HLEN_W   = 16;
  localparam int unsigned HIST_N   = 5;
  localparam int unsigned FILL_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HLEN_W-1:0] MAX_PAYLOAD = 16'd4096;
  localparam logic [FILL_W-1:0] HIST_FULL   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_START_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_B = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [FLEN_W-1:0] frame_length;
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              first_of_frame;
    logic              last_of_frame;
  } result_t;

endpackage

/* rtl/sync_length_frame_deframer_core.sv */
// Top level of the sync/length frame deframer: parser plus result register.
// Depends on slfd_pkg and slfd_parser.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | in_rx_byte
//  out_    | output    | out_valid/out_stall | command, frame_length, data_byte, flags
//  cfg_    | input     | cfg_we              | cfg_index, cfg_data
//
// One word is taken every clock while in_stall is low; its result, if any,
// is loaded into the result register as the word is taken. A new word is
// taken while a result waits, as long as the waiting result is taken in the
// same cycle. Reset clears the start bytes, the header fill and the payload
// state. in_stall follows out_stall only when the result register is occupied.
module sync_length_frame_deframer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [slfd_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [slfd_pkg::BYTE_W-1:0]    out_command,
  output logic [slfd_pkg::FLEN_W-1:0]    out_frame_length,
  output logic [slfd_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                           out_has_data,
  output logic                           out_first_of_frame,
  output logic                           out_last_of_frame,
  input  logic                           cfg_we,
  input  logic [slfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slfd_pkg::BYTE_W-1:0]    cfg_data
);

  logic              step;
  logic              res_valid;
  slfd_pkg::result_t res;
  slfd_pkg::result_t out_r;
  logic              out_valid_r, out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  slfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    if (step && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load only when the slot is free or being drained this cycle
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_command        = out_r.command;
  assign out_frame_length   = out_r.frame_length;
  assign out_data_byte      = out_r.data_byte;
  assign out_has_data       = out_r.has_data;
  assign out_first_of_frame = out_r.first_of_frame;
  assign out_last_of_frame  = out_r.last_of_frame;

endmodule

/* rtl/slfd_parser.sv */
// Header search and payload tracking for the deframer; one word per step.
// Depends on slfd_pkg. Result is combinational from the state and the word.
module slfd_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [slfd_pkg::BYTE_W-1:0]      rx_byte,
  input  logic                             cfg_we,
  input  logic [slfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slfd_pkg::BYTE_W-1:0]      cfg_data,
  output logic                             res_valid,
  output slfd_pkg::result_t                res
);

  logic [slfd_pkg::BYTE_W-1:0] start_a_r, start_b_r;
  logic [slfd_pkg::BYTE_W-1:0] hist_r   [slfd_pkg::HIST_N];
  logic [slfd_pkg::BYTE_W-1:0] hist_nxt [slfd_pkg::HIST_N];
  logic [slfd_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic                        in_payload_r, in_payload_nxt;
  logic [slfd_pkg::FLEN_W-1:0] remain_r, remain_nxt;
  logic [slfd_pkg::BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [slfd_pkg::FLEN_W-1:0] flen_r, flen_nxt;

  logic [slfd_pkg::HLEN_W-1:0] hdr_len;
  logic                        hdr_full;
  logic                        hdr_ok;

  // hist_r[4] is the newest stored word; the incoming word completes the header
  assign hdr_len  = {rx_byte, hist_r[4]};
  assign hdr_full = (fill_r == slfd_pkg::HIST_FULL);
  assign hdr_ok   = hdr_full && (hist_r[0] == start_a_r) && (hist_r[1] == start_b_r)
                    && (hdr_len <= slfd_pkg::MAX_PAYLOAD);

  always_comb begin
    for (int i = 0; i < slfd_pkg::HIST_N - 1; i++) begin
      hist_nxt[i] = hist_r[i+1];
    end
    hist_nxt[slfd_pkg::HIST_N-1] = rx_byte;
    fill_nxt       = fill_r;
    in_payload_nxt = in_payload_r;
    remain_nxt     = remain_r;
    cmd_nxt        = cmd_r;
    flen_nxt       = flen_r;
    res_valid      = 1'b0;
    res            = '0;

    if (in_payload_r) begin
      res_valid          = 1'b1;
      res.command        = cmd_r;
      res.frame_length   = flen_r;
      res.data_byte      = rx_byte;
      res.has_data       = 1'b1;
      res.first_of_frame = (remain_r == flen_r);
      res.last_of_frame  = (remain_r <= slfd_pkg::FLEN_W'(1));
      remain_nxt         = remain_r - slfd_pkg::FLEN_W'(1);
      if (remain_r <= slfd_pkg::FLEN_W'(1)) begin
        in_payload_nxt = 1'b0;
        fill_nxt       = '0;
        remain_nxt     = '0;
      end
    end else if (!hdr_full) begin
      fill_nxt = fill_r + slfd_pkg::FILL_W'(1);
    end else if (hdr_ok) begin
      fill_nxt = '0;
      cmd_nxt  = hist_r[2];
      flen_nxt = hdr_len[slfd_pkg::FLEN_W-1:0];
      if (hdr_len == '0) begin
        res_valid          = 1'b1;
        res.command        = hist_r[2];
        res.has_data       = 1'b0;
        res.first_of_frame = 1'b1;
        res.last_of_frame  = 1'b1;
      end else begin
        remain_nxt     = hdr_len[slfd_pkg::FLEN_W-1:0];
        in_payload_nxt = 1'b1;
      end
    end
    // bad header: drop the oldest word by shifting, fill stays full
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_a_r    <= '0;
      start_b_r    <= '0;
      fill_r       <= '0;
      in_payload_r <= 1'b0;
      remain_r     <= '0;
      cmd_r        <= '0;
      flen_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          slfd_pkg::REG_START_A: start_a_r <= cfg_data;
          slfd_pkg::REG_START_B: start_b_r <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        fill_r       <= fill_nxt;
        in_payload_r <= in_payload_nxt;
        remain_r     <= remain_nxt;
        cmd_r        <= cmd_nxt;
        flen_r       <= flen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for sync_length_frame_deframer_core.
// Depends on slfd_pkg and the deframer RTL. It predicts each deframed word from the
// accepted bytes and compares it with what the block delivers.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 4;
  localparam int HDR_BYTES   = 6;

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           in_valid    = 1'b0;
  logic                           in_stall;
  logic [slfd_pkg::BYTE_W-1:0]    in_rx_byte  = '0;
  logic                           out_valid;
  logic                           out_stall   = 1'b0;
  logic [slfd_pkg::BYTE_W-1:0]    out_command;
  logic [slfd_pkg::FLEN_W-1:0]    out_frame_length;
  logic [slfd_pkg::BYTE_W-1:0]    out_data_byte;
  logic                           out_has_data;
  logic                           out_first_of_frame;
  logic                           out_last_of_frame;
  logic                           cfg_we      = 1'b0;
  logic [slfd_pkg::CFG_IDX_W-1:0] cfg_index   = slfd_pkg::REG_START_A;
  logic [slfd_pkg::BYTE_W-1:0]    cfg_data    = '0;

  sync_length_frame_deframer_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_frame_length   (out_frame_length),
    .out_data_byte      (out_data_byte),
    .out_has_data       (out_has_data),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // byte stream waiting to be driven, and deframed words still to arrive
  logic [slfd_pkg::BYTE_W-1:0] rx_stream[$];
  slfd_pkg::result_t           deframed_q[$];

  int unsigned cycle_cnt = 0;
  int          errors    = 0;
  bit          in_fire   = 1'b0;
  bit          calm      = 1'b0;

  // start bytes used to build frames
  logic [slfd_pkg::BYTE_W-1:0] frame_a = '0;
  logic [slfd_pkg::BYTE_W-1:0] frame_b = '0;

  // deframer state as predicted
  logic [slfd_pkg::BYTE_W-1:0] chk_a = '0;
  logic [slfd_pkg::BYTE_W-1:0] chk_b = '0;
  logic [slfd_pkg::BYTE_W-1:0] win_bytes[HDR_BYTES] = '{default: '0};
  int                          win_fill     = 0;
  bit                          payload_on   = 1'b0;
  int                          payload_left = 0;
  logic [slfd_pkg::BYTE_W-1:0] frame_cmd    = '0;
  logic [slfd_pkg::HLEN_W-1:0] frame_len    = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic deframe_byte(input logic [slfd_pkg::BYTE_W-1:0] b);
    slfd_pkg::result_t           r;
    logic [slfd_pkg::HLEN_W-1:0] hdr_len;
    r = '0;
    if (payload_on) begin
      r.command        = frame_cmd;
      r.frame_length   = frame_len[slfd_pkg::FLEN_W-1:0];
      r.data_byte      = b;
      r.has_data       = 1'b1;
      r.first_of_frame = (payload_left == int'(frame_len));
      r.last_of_frame  = (payload_left <= 1);
      deframed_q.push_back(r);
      if (payload_left > 0) payload_left--;
      if (payload_left == 0) begin
        payload_on = 1'b0;
        win_fill   = 0;
      end
    end else begin
      if (win_fill >= HDR_BYTES) win_fill = HDR_BYTES - 1;
      win_bytes[win_fill] = b;
      win_fill++;
      if (win_fill == HDR_BYTES) begin
        hdr_len = {win_bytes[5], win_bytes[4]};
        if (win_bytes[0] != chk_a || win_bytes[1] != chk_b ||
            hdr_len > slfd_pkg::MAX_PAYLOAD) begin
          // drop the oldest byte and keep searching
          for (int i = 0; i < HDR_BYTES - 1; i++) win_bytes[i] = win_bytes[i+1];
          win_bytes[HDR_BYTES-1] = '0;
          win_fill = HDR_BYTES - 1;
        end else begin
          win_fill  = 0;
          frame_cmd = win_bytes[2];
          frame_len = hdr_len;
          if (hdr_len == '0) begin
            r.command        = frame_cmd;
            r.first_of_frame = 1'b1;
            r.last_of_frame  = 1'b1;
            deframed_q.push_back(r);
          end else begin
            payload_left = int'(hdr_len);
            payload_on   = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor: check delivered words, then track config writes and accepted bytes
  always @(posedge clk) begin
    slfd_pkg::result_t want;
    in_fire <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual cmd %0d len %0d data %0d",
                   $time, out_command, out_frame_length, out_data_byte);
          errors++;
        end else begin
          want = deframed_q.pop_front();
          cmp_field("command", 32'(want.command), 32'(out_command));
          cmp_field("frame_length", 32'(want.frame_length), 32'(out_frame_length));
          cmp_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
          cmp_field("has_data", 32'(want.has_data), 32'(out_has_data));
          cmp_field("first_of_frame", 32'(want.first_of_frame), 32'(out_first_of_frame));
          cmp_field("last_of_frame", 32'(want.last_of_frame), 32'(out_last_of_frame));
        end
      end
      if (cfg_we) begin
        if (cfg_index == slfd_pkg::REG_START_A) chk_a = cfg_data;
        else if (cfg_index == slfd_pkg::REG_START_B) chk_b = cfg_data;
      end
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
    end
  end

  // driver: hold the word until taken, then advance or idle
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 11);
    if (!in_valid || in_fire) begin
      if (rx_stream.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        in_valid   <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic push_header(input logic [slfd_pkg::BYTE_W-1:0] a, b, cmd,
                             input logic [slfd_pkg::HLEN_W-1:0] len, input int keep);
    logic [slfd_pkg::BYTE_W-1:0] hdr[HDR_BYTES];
    hdr = '{a, b, cmd, 8'($urandom), len[7:0], len[15:8]};
    for (int i = 0; i < keep; i++) rx_stream.push_back(hdr[i]);
  endtask

  task automatic push_frame(input logic [slfd_pkg::BYTE_W-1:0] cmd, input int len);
    push_header(frame_a, frame_b, cmd, 16'(len), HDR_BYTES);
    // sprinkle start bytes into the payload now and then
    repeat (len) begin
      if ($urandom_range(9) == 0) rx_stream.push_back($urandom_range(1) ? frame_a : frame_b);
      else rx_stream.push_back(8'($urandom));
    end
  endtask

  task automatic random_traffic(input int n);
    int base;
    int pick;
    int len;
    base = rx_stream.size();
    while (rx_stream.size() - base < n) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(300, 13) : $urandom_range(12, 0);
        push_frame(8'($urandom), len);
      end else if (pick < 74) begin
        push_header(frame_a ^ 8'($urandom_range(255, 1)), frame_b, 8'($urandom),
                    16'($urandom_range(12)), HDR_BYTES);
      end else if (pick < 78) begin
        push_header(frame_a, frame_b ^ 8'($urandom_range(255, 1)), 8'($urandom),
                    16'($urandom_range(12)), HDR_BYTES);
      end else if (pick < 84) begin
        push_header(frame_a, frame_b, 8'($urandom),
                    16'($urandom_range(65535, slfd_pkg::MAX_PAYLOAD + 1)), HDR_BYTES);
      end else if (pick < 92) begin
        push_header(frame_a, frame_b, 8'($urandom), 16'($urandom_range(12)),
                    $urandom_range(HDR_BYTES - 1, 1));
      end else begin
        repeat ($urandom_range(8, 1)) rx_stream.push_back(8'($urandom));
      end
    end
  endtask

  task automatic settle();
    while (rx_stream.size() != 0 || in_valid) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_starts(input logic [slfd_pkg::BYTE_W-1:0] a, b);
    cfg_we    <= 1'b1;
    cfg_index <= slfd_pkg::REG_START_A;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= slfd_pkg::REG_START_B;
    cfg_data  <= b;
    @(negedge clk);
    cfg_we  <= 1'b0;
    frame_a = a;
    frame_b = b;
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: start bytes still at their reset value
    push_frame(8'h00, 0);
    push_header(frame_a, frame_b, 8'hFF, 16'd2, HDR_BYTES);
    rx_stream.push_back(frame_a);
    rx_stream.push_back(frame_b);
    push_header(frame_a ^ 8'h80, frame_b, 8'h11, 16'd0, HDR_BYTES);
    push_header(frame_a, frame_b, 8'h22, slfd_pkg::MAX_PAYLOAD + 16'd1, HDR_BYTES);
    push_frame(8'h5A, 1);
    settle();

    set_starts(8'hA5, 8'h5A);
    random_traffic(200);
    settle();
    set_starts(8'hFF, 8'hFF);
    random_traffic(200);
    settle();
    set_starts(8'h00, 8'hFF);
    random_traffic(200);
    settle();

    // no idling on either side for a whole phase
    calm = 1'b1;
    set_starts(8'($urandom), 8'($urandom));
    random_traffic(300);
    settle();
    calm = 1'b0;

    set_starts(8'h00, 8'h00);
    random_traffic(200);
    settle();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
